// File: design/lts_pkg.sv
`timescale 1ns / 1ps

package lts_pkg;

	// result kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_EMPTY  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// token classes
	localparam logic [1:0] CLS_WORD    = 2'd0;
	localparam logic [1:0] CLS_BRACKET = 2'd1;
	localparam logic [1:0] CLS_OP      = 2'd2;
	localparam logic [1:0] CLS_QUOTE   = 2'd3;

	// characters
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7c;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_TILDE  = 8'h7e;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	// result slots per input transaction and queue geometry
	localparam int SLOTS       = 3;
	localparam int SLOT_W      = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [7:0] token_byte;
		logic [1:0] token_class;
		logic       token_first;
		logic       token_last;
		logic       line_error;
		logic       last_result;
	} out_item_t;

	typedef struct packed {
		out_item_t [SLOTS-1:0] slot;
	} bundle_t;

	// front to queue
	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} push_t;

	// queue to back
	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} head_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_bracket(input logic [7:0] c);
		return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
			(c == CH_RBRACK) || (c == CH_LBRACE) || (c == CH_RBRACE);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
			(c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
			(c == CH_AMP) || (c == CH_PIPE) || (c == CH_CARET) || (c == CH_PCT) ||
			(c == CH_TILDE);
	endfunction

	function automatic logic is_quote(input logic [7:0] c);
		return (c == CH_DQUOTE) || (c == CH_SQUOTE);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return !is_space(c) && !is_bracket(c) && !is_op(c) && !is_quote(c);
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		logic eq_pair;
		eq_pair = (b == CH_EQ) && ((a == CH_EQ) || (a == CH_BANG) || (a == CH_LT) ||
			(a == CH_GT) || (a == CH_PLUS) || (a == CH_MINUS) || (a == CH_STAR) ||
			(a == CH_SLASH) || (a == CH_PCT));
		return eq_pair || (a == CH_AMP && b == CH_AMP) || (a == CH_PIPE && b == CH_PIPE) ||
			(a == CH_MINUS && b == CH_GT);
	endfunction

	function automatic out_item_t mk_item(input logic [1:0] kind, input logic [7:0] b,
		input logic [1:0] cls, input logic first, input logic last, input logic err);
		out_item_t r;
		r.item_kind   = kind;
		r.token_byte  = b;
		r.token_class = cls;
		r.token_first = first;
		r.token_last  = last;
		r.line_error  = err;
		r.last_result = 1'b0;
		return r;
	endfunction

endpackage

// File: design/lts_front.sv
`timescale 1ns / 1ps

module lts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lts_pkg::in_item_t item_data,
	input  logic              q_full,
	output lts_pkg::push_t    push
);
	import lts_pkg::*;

	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [1:0] held_class_q;
	logic       held_first_q;
	logic       in_quote_q;
	logic       quote_is_single_q;
	logic       escape_armed_q;

	logic [7:0] nb;
	logic       nv;
	logic [1:0] nc;
	logic       nf;
	logic       niq;
	logic       nqs;
	logic       nea;
	logic [SLOT_W-1:0] n;
	bundle_t    b;
	logic [7:0] c;
	logic [7:0] qc;
	logic       taken;
	logic       first;
	logic       err;
	logic       accept;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		nb    = held_byte_q;
		nv    = held_valid_q;
		nc    = held_class_q;
		nf    = held_first_q;
		niq   = in_quote_q;
		nqs   = quote_is_single_q;
		nea   = escape_armed_q;
		n     = '0;
		b     = '0;
		c     = item_data.in_byte;
		qc    = quote_is_single_q ? CH_SQUOTE : CH_DQUOTE;
		taken = 1'b0;
		first = 1'b0;
		err   = 1'b0;

		if (in_quote_q) begin
			if (!escape_armed_q && c == qc) begin
				// closing quote
				if (nv) begin
					b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b1, 1'b0);
					nv = 1'b0;
				end else begin
					b.slot[n] = mk_item(KIND_EMPTY, 8'h00, CLS_QUOTE, 1'b1, 1'b1, 1'b0);
				end
				n   = n + 2'd1;
				niq = 1'b0;
			end else begin
				// quoted content, escaped byte taken raw
				nea   = !escape_armed_q && (c == CH_BSLASH);
				first = !nv;
				if (nv) begin
					b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b0, 1'b0);
					n = n + 2'd1;
				end
				nb = c;
				nc = CLS_QUOTE;
				nf = first;
				nv = 1'b1;
			end
		end else begin
			if (nv && nc == CLS_OP) begin
				if (is_pair(nb, c)) begin
					b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b0, 1'b0);
					n = n + 2'd1;
					b.slot[n] = mk_item(KIND_BYTE, c, CLS_OP, 1'b0, 1'b1, 1'b0);
					n = n + 2'd1;
					nv    = 1'b0;
					taken = 1'b1;
				end else begin
					b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b1, 1'b0);
					n  = n + 2'd1;
					nv = 1'b0;
				end
			end else if (nv) begin
				if (is_word(c)) begin
					b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b0, 1'b0);
					n  = n + 2'd1;
					nb = c;
					nc = CLS_WORD;
					nf = 1'b0;
					taken = 1'b1;
				end else begin
					b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b1, 1'b0);
					n  = n + 2'd1;
					nv = 1'b0;
				end
			end
			if (!taken) begin
				priority if (is_space(c)) begin
					nv = nv;
				end else if (is_bracket(c)) begin
					b.slot[n] = mk_item(KIND_BYTE, c, CLS_BRACKET, 1'b1, 1'b1, 1'b0);
					n = n + 2'd1;
				end else if (is_op(c)) begin
					nb = c;
					nc = CLS_OP;
					nf = 1'b1;
					nv = 1'b1;
				end else if (is_quote(c)) begin
					niq = 1'b1;
					nqs = (c == CH_SQUOTE);
					nea = 1'b0;
				end else begin
					nb = c;
					nc = CLS_WORD;
					nf = 1'b1;
					nv = 1'b1;
				end
			end
		end

		if (item_data.line_end) begin
			err = niq;
			if (nv) begin
				b.slot[n] = mk_item(KIND_BYTE, nb, nc, nf, 1'b1, 1'b0);
				n = n + 2'd1;
			end
			b.slot[n] = mk_item(KIND_STATUS, 8'h00, CLS_WORD, 1'b0, 1'b0, err);
			n   = n + 2'd1;
			nb  = '0;
			nv  = 1'b0;
			nc  = '0;
			nf  = 1'b0;
			niq = 1'b0;
			nqs = 1'b0;
			nea = 1'b0;
		end

		if (n != '0) begin
			b.slot[n - 2'd1].last_result = 1'b1;
		end
	end

	assign push.valid  = accept && (n != '0);
	assign push.bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q       <= '0;
			held_valid_q      <= 1'b0;
			held_class_q      <= '0;
			held_first_q      <= 1'b0;
			in_quote_q        <= 1'b0;
			quote_is_single_q <= 1'b0;
			escape_armed_q    <= 1'b0;
		end else if (accept) begin
			held_byte_q       <= nb;
			held_valid_q      <= nv;
			held_class_q      <= nc;
			held_first_q      <= nf;
			in_quote_q        <= niq;
			quote_is_single_q <= nqs;
			escape_armed_q    <= nea;
		end
	end

endmodule

// File: design/lts_queue.sv
`timescale 1ns / 1ps

module lts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  lts_pkg::push_t push,
	output logic           full,
	output lts_pkg::head_t head,
	input  logic           pop
);
	import lts_pkg::*;

	bundle_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full        = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid  = (count_q != '0);
	assign head.bundle = entry_q[rd_ptr_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/lts_back.sv
`timescale 1ns / 1ps

module lts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lts_pkg::head_t     head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output lts_pkg::out_item_t result_data
);
	import lts_pkg::*;

	logic [SLOT_W-1:0] idx_q;
	logic              result_valid_q;
	out_item_t         result_data_q;
	out_item_t         cur;
	logic              load;

	assign cur          = head.bundle.slot[idx_q];
	assign load         = !result_valid_q || !result_stall;
	assign pop          = load && head.valid && cur.last_result;
	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= cur.last_result ? '0 : idx_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			result_data_q <= cur;
		end
	end

endmodule

// File: design/line_token_splitter_unit.sv
// line token splitter
// item channel: one character per transaction (item_valid / item_stall / item_data),
//   item_data.line_end marks the final character of a text line
// result channel: token bytes with first/last marks and class, empty quoted tokens and
//   one end-of-line status per line (result_valid / result_stall / result_data);
//   last_result marks the final result caused by an input transaction
// a front stage classifies each character against the held lookahead byte and builds
// a bundle of up to three results; a four-entry bundle queue feeds a back stage that
// hands out one result per cycle through an output register while it is not stalled
// an accepted character's results pass the bundle queue, then the output register
// throughput: one character per cycle while characters average at most one result and
//   the receiver does not stall; bursts of multi-result characters fill the queue and
//   item_stall rises while it is full
// reset clears the held byte, the quote state, the queue and the output register
// a stalled receiver freezes the output register; the queue absorbs up to four more
// characters that cause results before item_stall is raised
// a status with line_error set means the line ended inside a quote: drop that line
`timescale 1ns / 1ps

module line_token_splitter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lts_pkg::in_item_t  item_data,
	output logic               result_valid,
	input  logic               result_stall,
	output lts_pkg::out_item_t result_data
);
	import lts_pkg::*;

	push_t q_push;
	head_t q_head;
	logic  q_full;
	logic  q_pop;

	// classification and lookahead state
	lts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.q_full     (q_full),
		.push       (q_push)
	);

	// bundle queue decoupling front and back
	lts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.head   (q_head),
		.pop    (q_pop)
	);

	// serializer and output register
	lts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// no bundle is pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push.valid)
		else $error("bundle pushed into full queue");

	// front only stalls when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> q_full)
		else $error("item stalled with queue space left");

	// a status always closes the results of its transaction
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.item_kind == KIND_STATUS |-> result_data.last_result)
		else $error("status result not marked last");

	// an empty quoted token is a whole token
	a_empty_whole: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.item_kind == KIND_EMPTY
			|-> result_data.token_first && result_data.token_last)
		else $error("empty token without first and last marks");

endmodule

// File: tb/lts_token_checker.sv
`timescale 1ns / 1ps

module lts_token_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  lts_pkg::in_item_t  item_data,
	input  logic               result_valid,
	input  logic               result_stall,
	input  lts_pkg::out_item_t result_data,
	output int                 mismatch_count,
	output int                 tokens_pending
);
	import lts_pkg::*;

	typedef enum logic [2:0] {GRP_WORD, GRP_BLANK, GRP_BRACKET, GRP_OP, GRP_QUOTE} char_grp_t;

	// lookahead byte and quote tracking
	logic [7:0] hold_byte;
	logic       hold_live;
	logic [1:0] hold_cls;
	logic       hold_start;
	logic       in_str;
	logic       str_single;
	logic       esc_next;

	out_item_t expected_tokens[$];
	out_item_t oldest;

	function automatic char_grp_t char_group(input logic [7:0] c);
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
			return GRP_BLANK;
		case (c)
		CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: return GRP_BRACKET;
		CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP,
		CH_PIPE, CH_CARET, CH_PCT, CH_TILDE: return GRP_OP;
		CH_DQUOTE, CH_SQUOTE: return GRP_QUOTE;
		default: return GRP_WORD;
		endcase
	endfunction

	function automatic logic forms_pair(input logic [7:0] a, input logic [7:0] b);
		if (b == CH_EQ) begin
			case (a)
			CH_EQ, CH_BANG, CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
			CH_PCT: return 1'b1;
			default: return 1'b0;
			endcase
		end
		return (a == CH_AMP && b == CH_AMP) || (a == CH_PIPE && b == CH_PIPE) ||
			(a == CH_MINUS && b == CH_GT);
	endfunction

	task automatic expect_token(input logic [1:0] kind, input logic [7:0] b,
		input logic [1:0] cls, input logic first, input logic last, input logic err);
		out_item_t t;
		t.item_kind   = kind;
		t.token_byte  = b;
		t.token_class = cls;
		t.token_first = first;
		t.token_last  = last;
		t.line_error  = err;
		t.last_result = 1'b0;
		expected_tokens.push_back(t);
	endtask

	task automatic release_held(input logic last);
		expect_token(KIND_BYTE, hold_byte, hold_cls, hold_start, last, 1'b0);
		hold_live = 1'b0;
	endtask

	task automatic take_byte(input logic [7:0] c, input logic [1:0] cls, input logic first);
		hold_byte  = c;
		hold_cls   = cls;
		hold_start = first;
		hold_live  = 1'b1;
	endtask

	task automatic store_quoted(input logic [7:0] c);
		logic first;
		first = !hold_live;
		if (hold_live)
			release_held(1'b0);
		take_byte(c, CLS_QUOTE, first);
	endtask

	task automatic clear_state();
		hold_byte  = 8'h00;
		hold_live  = 1'b0;
		hold_cls   = CLS_WORD;
		hold_start = 1'b0;
		in_str     = 1'b0;
		str_single = 1'b0;
		esc_next   = 1'b0;
	endtask

	// expected results of one character
	task automatic split_char(input in_item_t it);
		logic [7:0] c;
		logic       taken;
		int         base_count;
		out_item_t  tail;
		char_grp_t  grp;
		c = it.in_byte;
		taken = 1'b0;
		base_count = expected_tokens.size();
		grp = char_group(c);
		if (in_str) begin
			if (esc_next) begin
				esc_next = 1'b0;
				store_quoted(c);
			end else if (c == (str_single ? CH_SQUOTE : CH_DQUOTE)) begin
				if (hold_live)
					release_held(1'b1);
				else
					expect_token(KIND_EMPTY, 8'h00, CLS_QUOTE, 1'b1, 1'b1, 1'b0);
				in_str = 1'b0;
			end else begin
				if (c == CH_BSLASH)
					esc_next = 1'b1;
				store_quoted(c);
			end
		end else begin
			if (hold_live && hold_cls == CLS_OP) begin
				if (forms_pair(hold_byte, c)) begin
					release_held(1'b0);
					expect_token(KIND_BYTE, c, CLS_OP, 1'b0, 1'b1, 1'b0);
					taken = 1'b1;
				end else begin
					release_held(1'b1);
				end
			end else if (hold_live) begin
				if (grp == GRP_WORD) begin
					release_held(1'b0);
					take_byte(c, CLS_WORD, 1'b0);
					taken = 1'b1;
				end else begin
					release_held(1'b1);
				end
			end
			if (!taken) begin
				case (grp)
				GRP_BRACKET: expect_token(KIND_BYTE, c, CLS_BRACKET, 1'b1, 1'b1, 1'b0);
				GRP_OP: take_byte(c, CLS_OP, 1'b1);
				GRP_QUOTE: begin
					in_str = 1'b1;
					str_single = (c == CH_SQUOTE);
					esc_next = 1'b0;
				end
				GRP_WORD: take_byte(c, CLS_WORD, 1'b1);
				default: ;
				endcase
			end
		end
		if (it.line_end) begin
			if (hold_live)
				release_held(1'b1);
			expect_token(KIND_STATUS, 8'h00, CLS_WORD, 1'b0, 1'b0, in_str);
			clear_state();
		end
		if (expected_tokens.size() > base_count) begin
			tail = expected_tokens.pop_back();
			tail.last_result = 1'b1;
			expected_tokens.push_back(tail);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0h got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// results are matched before the same edge's character is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_tokens.delete();
			mismatch_count = 0;
			tokens_pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected result kind %0h byte %0h", result_data.item_kind,
						result_data.token_byte);
					mismatch_count++;
				end else begin
					oldest = expected_tokens.pop_front();
					check_field("item_kind", int'(oldest.item_kind),
						int'(result_data.item_kind));
					check_field("token_byte", int'(oldest.token_byte),
						int'(result_data.token_byte));
					check_field("token_class", int'(oldest.token_class),
						int'(result_data.token_class));
					check_field("token_first", int'(oldest.token_first),
						int'(result_data.token_first));
					check_field("token_last", int'(oldest.token_last),
						int'(result_data.token_last));
					check_field("line_error", int'(oldest.line_error),
						int'(result_data.line_error));
					check_field("last_result", int'(oldest.last_result),
						int'(result_data.last_result));
				end
			end
			if (item_valid && !item_stall)
				split_char(item_data);
			tokens_pending <= expected_tokens.size();
		end
	end

endmodule

// File: tb/tb_line_token_splitter_unit.sv
`timescale 1ns / 1ps

module tb_line_token_splitter_unit;
	import lts_pkg::*;

	// cycles with no transaction on either channel before the run is given up
	localparam int WATCHDOG_LIMIT = 2000;
	// settle time after the last result, covers the front stage and the bundle queue
	localparam int TAIL_CYCLES = 30;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	in_item_t  item_data = '0;
	logic      result_stall = 1'b0;
	logic      item_stall;
	logic      result_valid;
	out_item_t result_data;

	int mismatch_count;
	int tokens_pending;

	// idle odds in percent, sender side and receiver side
	int send_idle_pct = 15;
	int recv_idle_pct = 58;

	int chars_sent = 0;
	int quiet_cycles = 0;

	// characters of the line being built, sent in order
	logic [7:0] line_buf[$];

	string word_punct = "_.,;:#$@?";
	string op_chars = "+-*/=!<>&|^%~";
	string bracket_chars = "()[]{}";
	string op_pairs[12] = '{"==", "!=", "<=", ">=", "&&", "||", "+=", "-=", "*=", "/=", "%=",
		"->"};

	line_token_splitter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// watches both channels, predicts every result and counts mismatches
	lts_token_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item_data      (item_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_data    (result_data),
		.mismatch_count (mismatch_count),
		.tokens_pending (tokens_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// give up when no transaction moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// letters, digits, high bytes and punctuation that builds words
	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 3))
		0: return 8'h61 + 8'($urandom_range(0, 25));
		1: return 8'h30 + 8'($urandom_range(0, 9));
		2: return 8'($urandom_range(128, 255));
		default: return word_punct[$urandom_range(0, word_punct.len() - 1)];
		endcase
	endfunction

	// space or one of the control blanks tab through carriage return
	function automatic logic [7:0] blank_char();
		if ($urandom_range(0, 1))
			return CH_SPACE;
		return 8'($urandom_range(CH_TAB, CH_CR));
	endfunction

	// one character transaction; valid stays up between back-to-back characters
	task automatic send_char(input logic [7:0] c, input logic last_char);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= '{in_byte: c, line_end: last_char};
		do @(posedge clk); while (item_stall);
		chars_sent++;
	endtask

	// the last character of the buffer carries the line end mark
	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i], i == line_buf.size() - 1);
	endtask

	// sender holds off until every predicted result has come out
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
	endtask

	// quoted text with random content; open quotes only ever close the line
	task automatic add_quoted(input logic closed);
		logic [7:0] qc;
		int         len;
		qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
		line_buf.push_back(qc);
		len = $urandom_range(0, 4);
		repeat (len) begin
			case ($urandom_range(0, 4))
			0: line_buf.push_back(blank_char());
			1: line_buf.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
			2: line_buf.push_back(qc == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
			3: begin
				// escaped byte, often the closing quote itself
				line_buf.push_back(CH_BSLASH);
				line_buf.push_back($urandom_range(0, 1) ? qc : 8'($urandom_range(0, 255)));
			end
			default: line_buf.push_back(word_char());
			endcase
		end
		if (closed)
			line_buf.push_back(qc);
		else if ($urandom_range(0, 1))
			line_buf.push_back(CH_BSLASH);
	endtask

	// mostly well-formed token sequences, some raw noise bytes mixed in
	task automatic build_line();
		int n_tok;
		int wlen;
		int pick;
		line_buf.delete();
		n_tok = $urandom_range(1, 5);
		repeat (n_tok) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				wlen = $urandom_range(1, 4);
				repeat (wlen)
					line_buf.push_back(word_char());
			end
			2: line_buf.push_back(bracket_chars[$urandom_range(0, bracket_chars.len() - 1)]);
			3: line_buf.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
			4: begin
				pick = $urandom_range(0, 11);
				line_buf.push_back(op_pairs[pick][0]);
				line_buf.push_back(op_pairs[pick][1]);
			end
			5, 6: add_quoted(1'b1);
			7: line_buf.push_back(8'($urandom_range(0, 255)));
			default: line_buf.push_back(blank_char());
			endcase
			if ($urandom_range(0, 2) == 0)
				line_buf.push_back(blank_char());
		end
		// now and then the line ends inside a quote
		if ($urandom_range(0, 9) == 0)
			add_quoted(1'b0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nul and top byte as words, bracket, and-pair, empty quote, escaped single quote,
		// then a tilde alone at line end
		line_buf = '{8'h00, 8'hff, CH_LPAREN, CH_AMP, CH_AMP, CH_DQUOTE, CH_DQUOTE, CH_SQUOTE,
			CH_BSLASH, CH_SQUOTE, CH_SQUOTE, CH_SPACE, CH_TILDE};
		send_line();
		// line ends on a backslash inside a quote
		line_buf = '{CH_DQUOTE, 8'h61, CH_BSLASH};
		send_line();
		// leading tab, arrow, not-equal, delete byte as a word, bracket closing the line
		line_buf = '{CH_TAB, CH_MINUS, CH_GT, CH_BANG, CH_EQ, 8'h7f, CH_RBRACK};
		send_line();
		// blank line gives only the status
		line_buf = '{CH_SPACE};
		send_line();

		// sender idles lightly, receiver stalls often
		while (chars_sent < 90) begin
			build_line();
			send_line();
		end
		wait_drained();

		// roles swapped: sender idles often, receiver rarely stalls
		send_idle_pct = 58;
		recv_idle_pct <= 15;
		while (chars_sent < 155) begin
			build_line();
			send_line();
		end
		wait_drained();

		// full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		while (chars_sent < 215) begin
			build_line();
			send_line();
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && tokens_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
